FILE: sv/amt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the array multiset table.
package amt_pkg;

    // Widths of the request and result fields on the stream ports.
    localparam int IN_VALUE_W  = 32;
    localparam int FUNC_W      = 3;
    localparam int OCC_W       = 5;
    localparam int SIZE_W      = 5;
    localparam int ELEM_W      = 32;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 48;

    // Function codes carried in s_tuser.
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_COUNT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 3'd4;

    // Decoded operation; unknown function codes become OP_NOP.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_REMOVE,
        OP_COUNT,
        OP_CLEAR,
        OP_DUMP,
        OP_NOP
    } op_t;

    // One classified request waiting in the command queue.
    typedef struct packed {
        op_t                   op;
        logic [IN_VALUE_W-1:0] value;
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_DUMP,
        ST_FINISH
    } back_state_t;

endpackage

FILE: sv/amt_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, decodes the function code and queues commands.
module amt_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [amt_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] entry_value
    input  logic [amt_pkg::FUNC_W-1:0]     s_tuser,   // [2:0] func
    output logic                           cmd_valid,
    output amt_pkg::cmd_t                  cmd,
    input  logic                           cmd_pop
);
    import amt_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_t       cmd_in;

    always_comb begin
        cmd_in.value = s_tdata;
        unique case (s_tuser)
            FUNC_ADD:    cmd_in.op = OP_ADD;
            FUNC_REMOVE: cmd_in.op = OP_REMOVE;
            FUNC_COUNT:  cmd_in.op = OP_COUNT;
            FUNC_CLEAR:  cmd_in.op = OP_CLEAR;
            FUNC_DUMP:   cmd_in.op = OP_DUMP;
            default:     cmd_in.op = OP_NOP;
        endcase
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: sv/amt_back.sv
`timescale 1ns / 1ps
// Back end: entry memory, scan sequencer and the registered result stage.
module amt_back #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cmd_valid,
    input  amt_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [amt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import amt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    back_state_t            state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          occ_reg, occ_next;
    logic                   hit_reg, hit_next;
    logic [IW-1:0]          slot_reg, slot_next;
    logic [IW-1:0]          addr_d_reg, addr_d_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic                   ok_reg, ok_next;
    logic                   pend_reg, pend_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_ok_reg, out_found_reg, out_last_reg;
    logic [OCC_W-1:0]       out_occ_reg;
    logic [SIZE_W-1:0]      out_size_reg;
    logic [ELEM_W-1:0]      out_elem_reg;

    logic                   mem_we, mem_re;
    logic [IW-1:0]          mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;

    logic                   out_load;
    logic                   ld_ok, ld_found, ld_last;
    logic [ELEM_W-1:0]      ld_elem;

    logic                   can_load, match, stop_rm, last_now;
    logic [IW-1:0]          tail_addr;

    assign can_load  = !out_valid_reg || m_tready;
    assign match     = pend_reg && (rd_data_reg == val_reg);
    assign stop_rm   = (op_reg == OP_REMOVE) && (hit_reg || match);
    assign tail_addr = IW'(fill_reg - 1'b1);
    assign last_now  = pend_reg && (addr_d_reg == tail_addr);

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        occ_next    = occ_reg;
        hit_next    = hit_reg;
        slot_next   = slot_reg;
        addr_d_next = addr_d_reg;
        val_next    = val_reg;
        ok_next     = ok_reg;
        pend_next   = 1'b0;
        cmd_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = slot_reg;
        mem_raddr   = idx_reg[IW-1:0];
        mem_wdata   = val_reg;
        out_load    = 1'b0;
        ld_ok       = 1'b0;
        ld_found    = 1'b0;
        ld_last     = 1'b0;
        ld_elem     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop  = 1'b1;
                    op_next  = cmd.op;
                    val_next = VALUE_WIDTH'(cmd.value);
                    idx_next = '0;
                    occ_next = '0;
                    hit_next = 1'b0;
                    ok_next  = 1'b0;
                    unique case (cmd.op)
                        OP_ADD: begin
                            if (fill_reg < CW'(CAPACITY)) begin
                                mem_we    = 1'b1;
                                mem_waddr = fill_reg[IW-1:0];
                                mem_wdata = VALUE_WIDTH'(cmd.value);
                                fill_next = fill_reg + 1'b1;
                                ok_next   = 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                        OP_REMOVE, OP_COUNT: begin
                            state_next = (fill_reg == '0) ? ST_FINISH : ST_SCAN;
                        end
                        OP_CLEAR: begin
                            fill_next  = '0;
                            state_next = ST_FINISH;
                        end
                        OP_DUMP: begin
                            state_next = (fill_reg == '0) ? ST_FINISH : ST_DUMP;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Reads are issued one a cycle; each returns in the next cycle.
                if (match && (op_reg == OP_COUNT)) begin
                    occ_next = occ_reg + 1'b1;
                end
                if (match && (op_reg == OP_REMOVE) && !hit_reg) begin
                    hit_next  = 1'b1;
                    slot_next = addr_d_reg;
                end
                if ((idx_reg < fill_reg) && !stop_rm) begin
                    mem_re      = 1'b1;
                    mem_raddr   = idx_reg[IW-1:0];
                    addr_d_next = idx_reg[IW-1:0];
                    idx_next    = idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end else begin
                    state_next = stop_rm ? ST_MOVE_RD : ST_FINISH;
                end
            end

            ST_MOVE_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = tail_addr;
                state_next = ST_MOVE_WR;
            end

            ST_MOVE_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = slot_reg;
                mem_wdata  = rd_data_reg;
                fill_next  = fill_reg - 1'b1;
                ok_next    = 1'b1;
                state_next = ST_FINISH;
            end

            ST_DUMP: begin
                // The read register doubles as a holding stage while the
                // result register is stalled.
                pend_next = pend_reg && !can_load;
                if (pend_reg && can_load) begin
                    out_load = 1'b1;
                    ld_elem  = ELEM_W'(rd_data_reg);
                    ld_last  = last_now;
                    if (last_now) begin
                        state_next = ST_IDLE;
                    end
                end
                if ((idx_reg < fill_reg) && (!pend_reg || can_load)) begin
                    mem_re      = 1'b1;
                    mem_raddr   = idx_reg[IW-1:0];
                    addr_d_next = idx_reg[IW-1:0];
                    idx_next    = idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
            end

            ST_FINISH: begin
                if (can_load) begin
                    out_load   = 1'b1;
                    ld_ok      = ok_reg;
                    ld_found   = (occ_reg != '0);
                    ld_last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        occ_reg    <= occ_next;
        hit_reg    <= hit_next;
        slot_reg   <= slot_next;
        addr_d_reg <= addr_d_next;
        val_reg    <= val_next;
        ok_reg     <= ok_next;
        if (out_load) begin
            out_ok_reg    <= ld_ok;
            out_found_reg <= ld_found;
            out_occ_reg   <= ld_found ? OCC_W'(occ_reg) : '0;
            out_size_reg  <= SIZE_W'(fill_next);
            out_elem_reg  <= ld_elem;
            out_last_reg  <= ld_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_elem_reg, out_size_reg, out_occ_reg,
                       out_found_reg, out_ok_reg};

endmodule

FILE: sv/array_multiset_table.sv
`timescale 1ns / 1ps
// Top level of the array multiset table: front end, command queue and back end.
//
// This block keeps a bag of up to CAPACITY values of VALUE_WIDTH bits as a
// packed array plus a fill count. Each request on the s_ channel carries a
// function code in s_tuser and a value in s_tdata: add appends the value if
// there is room, remove replaces the first equal entry with the last one and
// shrinks the bag, count reports how many entries equal the value (found
// doubles as a contains query), clear empties the bag, and dump streams every
// entry in array order with m_tlast on the final one; an empty dump gives a
// single result with a zero element. Unknown function codes change nothing
// and return one result. Every result carries the bag size after the
// request, truncated to five bits. The front end decodes requests into a
// two-entry command queue, so it can keep accepting while the back end works
// and while a result waits in the output register. The back end owns a
// single-port entry memory with a registered read, and its scan of that
// memory sets how long a request takes: add, clear and unknown codes need
// no scan, count scans every entry, remove scans up to every entry (the scan
// stops at the first match and then copies the last entry into the hole),
// and dump streams one entry per cycle while m_tready stays high. The back
// end works on one request at a time. The memory needs no clearing after
// reset, since only entries below the fill count are ever read.
module array_multiset_table #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [amt_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] entry_value
    input  logic [amt_pkg::FUNC_W-1:0]     s_tuser,   // [2:0] func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata from bit 0: ok, found, occurrences[4:0], current_size[4:0],
    // element[31:0], four zero pad bits.
    output logic [amt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import amt_pkg::*;

    // Command handoff between the front end queue and the back end.
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    amt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    amt_back #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: sv/amt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the array multiset table, bound to the top level.
module amt_checker #(
    parameter int CAPACITY = 16
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [amt_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);

    // No result may be shown in the cycle after a reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // Success and found belong to different requests and never appear together.
    a_ok_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("ok and found both set");

    // Found is set exactly when the occurrence count is nonzero.
    a_found_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[6:2] != 5'd0) == m_tdata[1]))
        else $error("found disagrees with occurrences");

    // The reported size never exceeds the capacity.
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[11:7]) <= CAPACITY))
        else $error("size beyond capacity");

endmodule

bind array_multiset_table amt_checker #(.CAPACITY(CAPACITY)) u_amt_checker (.*);
